### sv/pehr_pkg.sv
`timescale 1ns / 1ps

package pehr_pkg;

	// Result kinds; the command queue reuses them as operation codes
	typedef enum logic [1:0] {
		KIND_ACCEPT = 2'd0,
		KIND_REJECT = 2'd1,
		KIND_NAK    = 2'd2,
		KIND_REPORT = 2'd3
	} kind_t;

	localparam int FRAC_W = 17;
	localparam logic [FRAC_W-1:0] FRAC_ONE = 17'd65536;

	// Full-scale report values
	localparam int SCALE_X = 15200;
	localparam int SCALE_Y = 9500;
	localparam int SCALE_P = 2047;

	// Report bytes and flag bits
	localparam logic [7:0] RPT_ID_STATUS  = 8'hC0;
	localparam logic [7:0] RPT_ID_PEN     = 8'h02;
	localparam logic [7:0] RPT_STATUS_END = 8'h01;
	localparam logic [7:0] RPT_TAIL       = 8'h1f;
	localparam logic [7:0] FLAG_BASE      = 8'h80 | 8'h40;
	localparam logic [7:0] FLAG_ACTIVE    = 8'h20;
	localparam logic [7:0] FLAG_TIP       = 8'h01;
	localparam logic [7:0] FLAG_SIDE1     = 8'h04;
	localparam logic [7:0] FLAG_SIDE2     = 8'h02;

	localparam int REPORT_LEN = 10;
	localparam int IDX_W = 4;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(REPORT_LEN - 1);

	// One stored pen event
	typedef struct packed {
		logic [2:0]        buttons;
		logic [FRAC_W-1:0] p;
		logic [FRAC_W-1:0] y;
		logic [FRAC_W-1:0] x;
	} event_t;

	// Command from the front to the back
	typedef struct packed {
		kind_t  op;
		event_t entry;
	} cmd_t;

	// Saturate a fraction at 1.0
	function automatic logic [FRAC_W-1:0] clamp_frac(input logic [FRAC_W-1:0] f);
		return (f > FRAC_ONE) ? FRAC_ONE : f;
	endfunction

endpackage

### sv/pehr_in_if.sv
`timescale 1ns / 1ps

interface pehr_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [16:0] x_pos;
	logic [16:0] y_pos;
	logic [16:0] tip_pressure;
	logic [2:0]  buttons;

	modport source (output valid, func, x_pos, y_pos, tip_pressure, buttons, input ready);
	modport sink (input valid, func, x_pos, y_pos, tip_pressure, buttons, output ready);
endinterface

### sv/pehr_out_if.sv
`timescale 1ns / 1ps

interface pehr_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] report_byte;
	logic       last;

	modport source (output valid, kind, report_byte, last, input ready);
	modport sink (input valid, kind, report_byte, last, output ready);
endinterface

### sv/pehr_cfg_if.sv
`timescale 1ns / 1ps

interface pehr_cfg_if;
	logic valid;
	logic ready;
	logic enabled;

	modport source (output valid, enabled, input ready);
	modport sink (input valid, enabled, output ready);
endinterface

### sv/pehr_front.sv
`timescale 1ns / 1ps

module pehr_front import pehr_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	pehr_in_if.sink       req,
	pehr_cfg_if.sink      cfg,
	output logic          push,
	output cmd_t          push_cmd,
	input  logic          full
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

	typedef enum logic [1:0] {
		F_IDLE = 2'b01,
		F_READ = 2'b10
	} front_state_t;

	front_state_t      state_q;
	logic              enabled_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [CNT_W-1:0]  cnt_q;
	event_t            mem [QUEUE_DEPTH];
	event_t            rd_data_q;
	event_t            ev;
	logic              accept;
	logic              q_full;
	logic              q_empty;
	logic              wr_en;
	logic              rd_en;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	// Enable register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q <= 1'b0;
		end else if (cfg.valid) begin
			enabled_q <= cfg.enabled;
		end
	end

	// Input handshake and classification
	assign req.ready = (state_q == F_IDLE) && !full;
	assign accept    = req.valid && req.ready;
	assign q_full    = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign q_empty   = (cnt_q == '0);
	assign wr_en     = accept && !req.func && enabled_q;
	assign rd_en     = accept && req.func && !q_empty;

	always_comb begin
		ev.x       = clamp_frac(req.x_pos);
		ev.y       = clamp_frac(req.y_pos);
		ev.p       = clamp_frac(req.tip_pressure);
		ev.buttons = req.buttons;
	end

	// Event store; read data registered
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_ptr_q] <= ev;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	// Queue pointers; a full queue drops its oldest entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else if (wr_en) begin
			wr_ptr_q <= ptr_next(wr_ptr_q);
			if (q_full) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end else if (rd_en) begin
			rd_ptr_q <= ptr_next(rd_ptr_q);
			cnt_q    <= cnt_q - 1'b1;
		end
	end

	// State: wait in F_READ for the popped entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			unique case (state_q)
				F_IDLE: if (rd_en) state_q <= F_READ;
				F_READ: state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// Command to the back
	always_comb begin
		push_cmd.entry = rd_data_q;
		push_cmd.op    = KIND_REPORT;
		push           = 1'b0;
		unique case (state_q)
			F_IDLE: begin
				push = accept && !rd_en;
				if (req.func) begin
					push_cmd.op = KIND_NAK;
				end else if (enabled_q) begin
					push_cmd.op = KIND_ACCEPT;
				end else begin
					push_cmd.op = KIND_REJECT;
				end
			end
			F_READ: begin
				push = 1'b1;
			end
			default: push = 1'b0;
		endcase
	end

endmodule

### sv/pehr_cmd_fifo.sv
`timescale 1ns / 1ps

module pehr_cmd_fifo import pehr_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output cmd_t pop_cmd,
	output logic empty
);

	cmd_t       slot_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign pop_cmd = slot_q[rd_q];

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_cmd;
		end
	end

	// Pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop)  rd_q <= ~rd_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### sv/pehr_back.sv
`timescale 1ns / 1ps

module pehr_back import pehr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	input  cmd_t      cmd,
	output logic      pop,
	pehr_out_if.source rsp
);

	typedef enum logic [2:0] {
		B_IDLE   = 3'b001,
		B_SCALE  = 3'b010,
		B_STREAM = 3'b100
	} back_state_t;

	back_state_t      state_q;
	event_t           ev_s1;
	logic [15:0]      x_s2;
	logic [15:0]      y_s2;
	logic [15:0]      p_s2;
	logic [7:0]       flags_s2;
	logic             status_s2;
	logic [IDX_W-1:0] idx_q;
	logic             rsp_valid_q;
	kind_t            kind_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic             out_free;
	logic             out_load;
	logic             active;
	logic [30:0]      prod_x;
	logic [30:0]      prod_y;
	logic [30:0]      prod_p;
	logic [7:0]       rpt_byte;

	assign out_free    = !rsp_valid_q || rsp.ready;
	assign rsp.valid   = rsp_valid_q;
	assign rsp.kind    = kind_q;
	assign rsp.report_byte = byte_q;
	assign rsp.last    = last_q;

	// Take a command while idle: reports always, single results only when the output is free
	assign pop = (state_q == B_IDLE) && cmd_valid
		&& ((cmd.op == KIND_REPORT) || out_free);

	// Output register takes a new item this cycle
	assign out_load = (pop && (cmd.op != KIND_REPORT))
		|| ((state_q == B_STREAM) && out_free);

	// Scaling products
	assign active = (ev_s1.buttons != '0) || (ev_s1.p != '0);
	assign prod_x = 31'(ev_s1.x) * 31'(SCALE_X);
	assign prod_y = 31'(ev_s1.y) * 31'(SCALE_Y);
	assign prod_p = 31'(ev_s1.p) * 31'(SCALE_P);

	always_ff @(posedge clk) begin
		if (pop) begin
			ev_s1 <= cmd.entry;
		end
		if (state_q == B_SCALE) begin
			x_s2      <= 16'(prod_x[30:16]);
			y_s2      <= 16'(prod_y[30:16]);
			p_s2      <= active ? 16'(prod_p[30:16]) : 16'd0;
			status_s2 <= (ev_s1 == '0);
			flags_s2  <= FLAG_BASE
				| (active ? FLAG_ACTIVE : 8'h00)
				| (ev_s1.buttons[0] ? FLAG_TIP : 8'h00)
				| (ev_s1.buttons[1] ? FLAG_SIDE1 : 8'h00)
				| (ev_s1.buttons[2] ? FLAG_SIDE2 : 8'h00);
		end
	end

	// Report byte select
	always_comb begin
		case (idx_q)
			4'd0:    rpt_byte = status_s2 ? RPT_ID_STATUS : RPT_ID_PEN;
			4'd1:    rpt_byte = status_s2 ? 8'h00 : flags_s2;
			4'd2:    rpt_byte = x_s2[7:0];
			4'd3:    rpt_byte = x_s2[15:8];
			4'd4:    rpt_byte = y_s2[7:0];
			4'd5:    rpt_byte = y_s2[15:8];
			4'd6:    rpt_byte = p_s2[7:0];
			4'd7:    rpt_byte = p_s2[15:8];
			4'd8:    rpt_byte = status_s2 ? 8'h00 : RPT_TAIL;
			4'd9:    rpt_byte = status_s2 ? RPT_STATUS_END : 8'h00;
			default: rpt_byte = 8'h00;
		endcase
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
			kind_q      <= KIND_ACCEPT;
			byte_q      <= 8'h00;
			last_q      <= 1'b0;
		end else begin
			rsp_valid_q <= out_load || (rsp_valid_q && !rsp.ready);
			unique case (state_q)
				B_IDLE: begin
					if (pop) begin
						if (cmd.op == KIND_REPORT) begin
							state_q <= B_SCALE;
						end else begin
							kind_q <= cmd.op;
							byte_q <= 8'h00;
							last_q <= 1'b1;
						end
					end
				end
				B_SCALE: begin
					idx_q   <= '0;
					state_q <= B_STREAM;
				end
				B_STREAM: begin
					if (out_free) begin
						kind_q <= KIND_REPORT;
						byte_q <= rpt_byte;
						last_q <= (idx_q == IDX_LAST);
						idx_q  <= idx_q + 1'b1;
						if (idx_q == IDX_LAST) begin
							state_q <= B_IDLE;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

### sv/pen_event_queue_hid_reporter.sv
`timescale 1ns / 1ps

// Pen event queue with HID report output. The front takes one item per cycle
// while the two-entry command queue has room: an event is stored (oldest
// dropped when the store is full) or rejected while disabled, a poll of an
// empty store answers NAK; a poll that pops an entry holds off the next input
// while the registered event store read completes. The back turns each
// command into results: one result, or for a popped entry the take of the
// command, a scaling state and then ten report bytes at one per cycle while
// the output is taken. The output register lets the front keep accepting
// while a result waits.
module pen_event_queue_hid_reporter import pehr_pkg::*; #(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	pehr_in_if.sink    req,
	pehr_cfg_if.sink   cfg,
	pehr_out_if.source rsp
);

	logic push;
	cmd_t push_cmd;
	logic full;
	logic pop;
	cmd_t pop_cmd;
	logic empty;

	// Front: classify items and keep the event store
	pehr_front #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg      (cfg),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full)
	);

	// Command queue between front and back
	pehr_cmd_fifo u_cmd_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (empty)
	);

	// Back: scaling and report streaming
	pehr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (!empty),
		.cmd       (pop_cmd),
		.pop       (pop),
		.rsp       (rsp)
	);

endmodule
